FILE: rtl/pfn_pkg.sv
// ----------------------------------------------------------------------------
// pfn_pkg
// Shared widths, types and state codes of the polygon facet normal block.
// ----------------------------------------------------------------------------
package pfn_pkg;

	// Corner coordinates carry 12 fraction bits; the fraction only fixes units.
	localparam int COORD_WIDTH  = 24;
	localparam int NORMAL_WIDTH = 16;
	localparam int THR_WIDTH    = 20;
	localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(2);

	localparam int EDGE_W   = COORD_WIDTH + 1;
	localparam int CROSS_W  = 2 * COORD_WIDTH + 2;
	localparam int MUL_W    = 32;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int ACC_W    = 64;
	localparam int R_W      = 31;
	localparam int ROOT_W   = 32;
	localparam int SQ_ITERS = ROOT_W;
	localparam int IT_W     = $clog2(SQ_ITERS);
	localparam int QW       = NORMAL_WIDTH - 1;
	localparam int DVD_W    = R_W + QW + 1;
	localparam int SCALE    = 2 ** QW - 1;
	localparam int SREM_W   = ROOT_W + 3;

	typedef logic signed [COORD_WIDTH-1:0]  coord_t;
	typedef logic signed [EDGE_W-1:0]       edge_t;
	typedef logic signed [CROSS_W-1:0]      cross_t;
	typedef logic        [CROSS_W-1:0]      mag_t;
	typedef logic signed [NORMAL_WIDTH-1:0] norm_t;
	typedef logic        [1:0]              idx_t;

	localparam norm_t NORM_MIN = {1'b1, {(NORMAL_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic             quad;
		coord_t [3:0]     px;
		coord_t [3:0]     py;
		coord_t [3:0]     pz;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} push_t;

	typedef struct packed {
		norm_t nx;
		norm_t ny;
		norm_t nz;
		idx_t  ca;
		idx_t  cb;
		idx_t  cc;
		logic  last;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD_DIAG,
		ST_LOAD_FACET,
		ST_MUL,
		ST_CHECK,
		ST_NORM,
		ST_SQRT,
		ST_DIV,
		ST_NEXT,
		ST_FLUSH0,
		ST_FLUSH1
	} back_state_t;

	typedef enum logic [1:0] {
		MM_DIAG,
		MM_CROSS,
		MM_RSQ,
		MM_SCALE
	} mul_mode_t;

endpackage

FILE: rtl/pfn_front.sv
// ----------------------------------------------------------------------------
// pfn_front
// Collects polygon corners and hands each polygon of three or more corners to the job queue.
// ----------------------------------------------------------------------------
module pfn_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  pfn_pkg::coord_t vertex_x,
	input  pfn_pkg::coord_t vertex_y,
	input  pfn_pkg::coord_t vertex_z,
	input  logic            last_vertex,
	input  logic            q_full,
	output pfn_pkg::push_t  q_push
);
	import pfn_pkg::*;

	coord_t     sx_q [4];
	coord_t     sy_q [4];
	coord_t     sz_q [4];
	logic [2:0] count_q;
	logic [2:0] n_corners;
	logic       accept;

	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign n_corners = count_q[2] ? 3'd4 : count_q + 3'd1;

	// The corner arriving now is bypassed into the job it completes.
	always_comb begin
		q_push.push     = accept && last_vertex && (n_corners >= 3'd3);
		q_push.job.quad = (n_corners == 3'd4);
		for (int i = 0; i < 4; i++) begin
			if (!count_q[2] && count_q[1:0] == 2'(i)) begin
				q_push.job.px[i] = vertex_x;
				q_push.job.py[i] = vertex_y;
				q_push.job.pz[i] = vertex_z;
			end else begin
				q_push.job.px[i] = sx_q[i];
				q_push.job.py[i] = sy_q[i];
				q_push.job.pz[i] = sz_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !count_q[2]) begin
			sx_q[count_q[1:0]] <= vertex_x;
			sy_q[count_q[1:0]] <= vertex_y;
			sz_q[count_q[1:0]] <= vertex_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (last_vertex) begin
				count_q <= '0;
			end else if (!count_q[2]) begin
				count_q <= count_q + 3'd1;
			end
		end
	end

endmodule

FILE: rtl/pfn_queue.sv
// ----------------------------------------------------------------------------
// pfn_queue
// Two-entry job queue between the corner front end and the facet engine.
// ----------------------------------------------------------------------------
module pfn_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  pfn_pkg::push_t q_push,
	output logic           q_full,
	input  logic           pop,
	output logic           q_valid,
	output pfn_pkg::job_t  q_job
);
	import pfn_pkg::*;

	job_t       mem [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;

	assign q_full  = fill_q[1];
	assign q_valid = (fill_q != 2'd0);
	assign q_job   = mem[rd_q];

	always_ff @(posedge clk) begin
		if (q_push.push) begin
			mem[wr_q] <= q_push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (q_push.push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({q_push.push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: rtl/pfn_back.sv
// ----------------------------------------------------------------------------
// pfn_back
// Facet engine: diagonal choice, cross product, degenerate test and unit
// normal through one shared multiplier, a square root and three dividers.
// ----------------------------------------------------------------------------
module pfn_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  pfn_pkg::job_t               q_job,
	output logic                        pop,
	input  logic [pfn_pkg::THR_WIDTH-1:0] thr,
	output logic                        out_valid,
	input  logic                        out_stall,
	output pfn_pkg::result_t            out_data
);
	import pfn_pkg::*;

	back_state_t state_q, state_d;
	mul_mode_t   mode_q;
	logic [2:0]  step_q;
	logic [2:0]  mul_n;
	logic [2:0]  jd;
	logic [IT_W-1:0] it_q;

	edge_t  ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
	cross_t cr_q [3];
	mag_t   rr_q [3];
	logic   ng_q [3];
	mag_t   orv;
	logic   norm_done;
	logic   below_thr, all_zero;
	mag_t   mg [3];

	logic signed [MUL_W-1:0]  opa, opb;
	logic signed [PROD_W-1:0] prod_q;
	logic [ACC_W-1:0] acc_q, sum_d, diag02_q;

	logic [ACC_W-1:0]  rad_q;
	logic [SREM_W-1:0] srem_q, st, strial;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W-1:0] rem_q [3];
	logic [QW-1:0]     low_q [3];
	logic [QW-1:0]     quo_q [3];
	logic [DVD_W-1:0]  dvd;

	logic    split02_q, fi_q, final_f;
	idx_t    fa, fb, fc;
	result_t res_q, held_q, out_q;
	result_t fin_res;
	logic    res_ok_q, held_v_q, out_v_q;
	logic    out_free, emit;
	result_t emit_data;

	assign out_free  = !out_v_q || !out_stall;
	assign out_valid = out_v_q;
	assign out_data  = out_q;
	assign final_f   = !q_job.quad || fi_q;
	assign jd        = step_q - 3'd1;
	assign sum_d     = acc_q + ACC_W'(prod_q);

	// Facet corners for the current split and facet number.
	always_comb begin
		if (split02_q) begin
			fa = 2'd0;
			fb = fi_q ? 2'd2 : 2'd1;
			fc = fi_q ? 2'd3 : 2'd2;
		end else begin
			fa = fi_q ? 2'd1 : 2'd0;
			fb = fi_q ? 2'd2 : 2'd1;
			fc = 2'd3;
		end
	end

	always_comb begin
		case (mode_q)
			MM_DIAG, MM_CROSS: mul_n = 3'd6;
			default:           mul_n = 3'd3;
		endcase
	end

	// Multiplier operand selection.
	always_comb begin
		opa = '0;
		opb = '0;
		case (mode_q)
			MM_DIAG: begin
				case (step_q)
					3'd0:    begin opa = MUL_W'(ux_q); opb = MUL_W'(ux_q); end
					3'd1:    begin opa = MUL_W'(uy_q); opb = MUL_W'(uy_q); end
					3'd2:    begin opa = MUL_W'(uz_q); opb = MUL_W'(uz_q); end
					3'd3:    begin opa = MUL_W'(vx_q); opb = MUL_W'(vx_q); end
					3'd4:    begin opa = MUL_W'(vy_q); opb = MUL_W'(vy_q); end
					default: begin opa = MUL_W'(vz_q); opb = MUL_W'(vz_q); end
				endcase
			end
			MM_CROSS: begin
				case (step_q)
					3'd0:    begin opa = MUL_W'(uy_q); opb = MUL_W'(vz_q); end
					3'd1:    begin opa = MUL_W'(uz_q); opb = MUL_W'(vy_q); end
					3'd2:    begin opa = MUL_W'(uz_q); opb = MUL_W'(vx_q); end
					3'd3:    begin opa = MUL_W'(ux_q); opb = MUL_W'(vz_q); end
					3'd4:    begin opa = MUL_W'(ux_q); opb = MUL_W'(vy_q); end
					default: begin opa = MUL_W'(uy_q); opb = MUL_W'(vx_q); end
				endcase
			end
			MM_RSQ: begin
				case (step_q)
					3'd0:    begin opa = MUL_W'(rr_q[0][R_W-1:0]); opb = MUL_W'(rr_q[0][R_W-1:0]); end
					3'd1:    begin opa = MUL_W'(rr_q[1][R_W-1:0]); opb = MUL_W'(rr_q[1][R_W-1:0]); end
					default: begin opa = MUL_W'(rr_q[2][R_W-1:0]); opb = MUL_W'(rr_q[2][R_W-1:0]); end
				endcase
			end
			default: begin
				case (step_q)
					3'd0:    opa = MUL_W'(rr_q[0][R_W-1:0]);
					3'd1:    opa = MUL_W'(rr_q[1][R_W-1:0]);
					default: opa = MUL_W'(rr_q[2][R_W-1:0]);
				endcase
				opb = MUL_W'(SCALE);
			end
		endcase
	end

	// Degenerate test on the cross product magnitudes.
	always_comb begin
		below_thr = 1'b1;
		all_zero  = 1'b1;
		for (int i = 0; i < 3; i++) begin
			mg[i] = cr_q[i][CROSS_W-1] ? mag_t'(-cr_q[i]) : mag_t'(cr_q[i]);
			if (mg[i] >= CROSS_W'(thr)) begin
				below_thr = 1'b0;
			end
			if (cr_q[i] != '0) begin
				all_zero = 1'b0;
			end
		end
	end

	// Finished facet: the quotients take the signs of the cross product.
	always_comb begin
		fin_res = res_q;
		if (res_ok_q && !all_zero) begin
			fin_res.nx = ng_q[0] ? -norm_t'(quo_q[0]) : norm_t'(quo_q[0]);
			fin_res.ny = ng_q[1] ? -norm_t'(quo_q[1]) : norm_t'(quo_q[1]);
			fin_res.nz = ng_q[2] ? -norm_t'(quo_q[2]) : norm_t'(quo_q[2]);
		end
	end

	assign orv       = rr_q[0] | rr_q[1] | rr_q[2];
	assign norm_done = (orv[CROSS_W-1:R_W] == '0) && orv[R_W-1];
	assign dvd       = DVD_W'(prod_q) + DVD_W'(root_q >> 1);
	assign st        = {srem_q[ROOT_W:0], rad_q[ACC_W-1 -: 2]};
	assign strial    = {1'b0, root_q, 2'b01};

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:       if (q_valid) state_d = q_job.quad ? ST_LOAD_DIAG : ST_LOAD_FACET;
			ST_LOAD_DIAG:  state_d = ST_MUL;
			ST_LOAD_FACET: state_d = ST_MUL;
			ST_MUL: begin
				if (step_q == mul_n) begin
					case (mode_q)
						MM_DIAG:  state_d = ST_LOAD_FACET;
						MM_CROSS: state_d = ST_CHECK;
						MM_RSQ:   state_d = ST_SQRT;
						default:  state_d = ST_DIV;
					endcase
				end
			end
			ST_CHECK:  state_d = (below_thr || all_zero) ? ST_NEXT : ST_NORM;
			ST_NORM:   if (norm_done) state_d = ST_MUL;
			ST_SQRT:   if (it_q == '0) state_d = ST_MUL;
			ST_DIV:    if (it_q == '0) state_d = ST_NEXT;
			ST_NEXT:   state_d = final_f ? ST_FLUSH0 : ST_LOAD_FACET;
			ST_FLUSH0: if (!held_v_q || out_free) state_d = ST_FLUSH1;
			ST_FLUSH1: if (!res_ok_q || out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Queue pop and result emission.
	always_comb begin
		pop       = 1'b0;
		emit      = 1'b0;
		emit_data = res_q;
		case (state_q)
			ST_FLUSH0: begin
				emit           = held_v_q && out_free;
				emit_data      = held_q;
				emit_data.last = !res_ok_q;
			end
			ST_FLUSH1: begin
				emit           = res_ok_q && out_free;
				emit_data.last = 1'b1;
				pop            = !res_ok_q || out_free;
			end
			default: begin
				pop  = 1'b0;
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			out_v_q  <= 1'b0;
			held_v_q <= 1'b0;
			res_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE:  held_v_q <= 1'b0;
				ST_CHECK: res_ok_q <= !below_thr;
				ST_NEXT:  if (!final_f) held_v_q <= res_ok_q;
				default:  res_ok_q <= res_ok_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= opa * opb;
		if (emit) begin
			out_q <= emit_data;
		end
		case (state_q)
			ST_IDLE: begin
				split02_q <= 1'b1;
				fi_q      <= 1'b0;
			end
			ST_LOAD_DIAG: begin
				ux_q   <= EDGE_W'(q_job.px[0]) - EDGE_W'(q_job.px[2]);
				uy_q   <= EDGE_W'(q_job.py[0]) - EDGE_W'(q_job.py[2]);
				uz_q   <= EDGE_W'(q_job.pz[0]) - EDGE_W'(q_job.pz[2]);
				vx_q   <= EDGE_W'(q_job.px[1]) - EDGE_W'(q_job.px[3]);
				vy_q   <= EDGE_W'(q_job.py[1]) - EDGE_W'(q_job.py[3]);
				vz_q   <= EDGE_W'(q_job.pz[1]) - EDGE_W'(q_job.pz[3]);
				mode_q <= MM_DIAG;
				step_q <= '0;
				acc_q  <= '0;
			end
			ST_LOAD_FACET: begin
				ux_q     <= EDGE_W'(q_job.px[fb]) - EDGE_W'(q_job.px[fa]);
				uy_q     <= EDGE_W'(q_job.py[fb]) - EDGE_W'(q_job.py[fa]);
				uz_q     <= EDGE_W'(q_job.pz[fb]) - EDGE_W'(q_job.pz[fa]);
				vx_q     <= EDGE_W'(q_job.px[fc]) - EDGE_W'(q_job.px[fa]);
				vy_q     <= EDGE_W'(q_job.py[fc]) - EDGE_W'(q_job.py[fa]);
				vz_q     <= EDGE_W'(q_job.pz[fc]) - EDGE_W'(q_job.pz[fa]);
				res_q.ca <= fa;
				res_q.cb <= fb;
				res_q.cc <= fc;
				res_q.last <= 1'b0;
				mode_q   <= MM_CROSS;
				step_q   <= '0;
				acc_q    <= '0;
			end
			ST_MUL: begin
				if (step_q != mul_n) begin
					step_q <= step_q + 3'd1;
				end
				if (step_q != '0) begin
					case (mode_q)
						MM_DIAG: begin
							if (jd == 3'd2) begin
								diag02_q <= sum_d;
								acc_q    <= '0;
							end else if (jd == 3'd5) begin
								split02_q <= (diag02_q < sum_d);
							end else begin
								acc_q <= sum_d;
							end
						end
						MM_CROSS: begin
							if (!jd[0]) begin
								acc_q <= ACC_W'(prod_q);
							end else begin
								cr_q[jd[2:1]] <= CROSS_W'(acc_q - ACC_W'(prod_q));
							end
						end
						MM_RSQ: begin
							acc_q <= sum_d;
							if (jd == 3'd2) begin
								rad_q  <= sum_d;
								srem_q <= '0;
								root_q <= '0;
								it_q   <= IT_W'(SQ_ITERS - 1);
							end
						end
						default: begin
							rem_q[jd[1:0]] <= dvd[DVD_W-1:QW];
							low_q[jd[1:0]] <= dvd[QW-1:0];
							quo_q[jd[1:0]] <= '0;
							it_q           <= IT_W'(QW - 1);
						end
					endcase
				end
			end
			ST_CHECK: begin
				for (int i = 0; i < 3; i++) begin
					rr_q[i] <= mg[i];
					ng_q[i] <= cr_q[i][CROSS_W-1];
				end
				res_q.nx <= '0;
				res_q.ny <= '0;
				res_q.nz <= '0;
			end
			ST_NORM: begin
				// Bring the largest magnitude to exactly R_W bits.
				for (int i = 0; i < 3; i++) begin
					if (orv[CROSS_W-1:R_W+3] != '0) begin
						rr_q[i] <= rr_q[i] >> 4;
					end else if (orv[CROSS_W-1:R_W] != '0) begin
						rr_q[i] <= rr_q[i] >> 1;
					end else if (orv[R_W-1:R_W-4] == '0) begin
						rr_q[i] <= rr_q[i] << 4;
					end else if (!orv[R_W-1]) begin
						rr_q[i] <= rr_q[i] << 1;
					end
				end
				if (norm_done) begin
					mode_q <= MM_RSQ;
					step_q <= '0;
					acc_q  <= '0;
				end
			end
			ST_SQRT: begin
				rad_q <= rad_q << 2;
				if (st >= strial) begin
					srem_q <= st - strial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					srem_q <= st;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
				it_q <= it_q - 1'b1;
				if (it_q == '0) begin
					mode_q <= MM_SCALE;
					step_q <= '0;
				end
			end
			ST_DIV: begin
				for (int i = 0; i < 3; i++) begin
					if ({rem_q[i], low_q[i][QW-1]} >= {1'b0, root_q}) begin
						rem_q[i] <= ROOT_W'({rem_q[i], low_q[i][QW-1]} - {1'b0, root_q});
						quo_q[i] <= {quo_q[i][QW-2:0], 1'b1};
					end else begin
						rem_q[i] <= ROOT_W'({rem_q[i], low_q[i][QW-1]});
						quo_q[i] <= {quo_q[i][QW-2:0], 1'b0};
					end
					low_q[i] <= low_q[i] << 1;
				end
				it_q <= it_q - 1'b1;
			end
			ST_NEXT: begin
				if (!final_f) begin
					held_q <= fin_res;
					fi_q   <= 1'b1;
				end
			end
			default: begin
				fi_q <= fi_q;
			end
		endcase
		// The dividers finish on the last DIV cycle; sign the quotients after.
		if (state_q == ST_NEXT) begin
			res_q <= fin_res;
		end
	end

endmodule

FILE: rtl/polygon_facet_normals.sv
// ----------------------------------------------------------------------------
// polygon_facet_normals
// Splits triangles and quads into facets and sends each facet's unit normal.
// ----------------------------------------------------------------------------
// Corners stream in one per transaction and are taken in every cycle while
// the two-entry polygon queue has room; a polygon enters the queue with its
// last corner. The facet engine then works on one polygon at a time: a quad
// first chooses its diagonal, and each facet goes through the 32-step square
// root and the 15-step dividers (three in parallel), with one shared 32x32
// multiplier for the cross product, squares and scaling. Facets whose cross
// product magnitudes all fall below the configured threshold are dropped, and
// last_facet marks the final facet actually sent for a polygon, so a quad's
// first facet is held until its second has been judged. Results sit in an
// output register, so the engine moves on while a result waits to be taken.
module polygon_facet_normals (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [pfn_pkg::THR_WIDTH-1:0] cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  pfn_pkg::coord_t               vertex_x,
	input  pfn_pkg::coord_t               vertex_y,
	input  pfn_pkg::coord_t               vertex_z,
	input  logic                          last_vertex,
	output logic                          out_valid,
	input  logic                          out_stall,
	output pfn_pkg::norm_t                normal_x,
	output pfn_pkg::norm_t                normal_y,
	output pfn_pkg::norm_t                normal_z,
	output pfn_pkg::idx_t                 corner_a,
	output pfn_pkg::idx_t                 corner_b,
	output pfn_pkg::idx_t                 corner_c,
	output logic                          last_facet
);
	import pfn_pkg::*;

	logic [THR_WIDTH-1:0] thr_q;
	push_t   q_push;
	logic    q_full, q_valid, pop;
	job_t    q_job;
	result_t res;

	// The threshold register; the user must write it only while the block is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	pfn_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.vertex_z    (vertex_z),
		.last_vertex (last_vertex),
		.q_full      (q_full),
		.q_push      (q_push)
	);

	pfn_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (q_push),
		.q_full  (q_full),
		.pop     (pop),
		.q_valid (q_valid),
		.q_job   (q_job)
	);

	pfn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_job     (q_job),
		.pop       (pop),
		.thr       (thr_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (res)
	);

	assign normal_x   = res.nx;
	assign normal_y   = res.ny;
	assign normal_z   = res.nz;
	assign corner_a   = res.ca;
	assign corner_b   = res.cb;
	assign corner_c   = res.cc;
	assign last_facet = res.last;

endmodule

FILE: rtl/pfn_checker.sv
// ----------------------------------------------------------------------------
// pfn_checker
// Port-level checks of the facet normal block, bound to the top level.
// ----------------------------------------------------------------------------
module pfn_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_wr_en,
	input logic [pfn_pkg::THR_WIDTH-1:0] cfg_wr_data,
	input logic                          in_valid,
	input logic                          in_stall,
	input pfn_pkg::coord_t               vertex_x,
	input pfn_pkg::coord_t               vertex_y,
	input pfn_pkg::coord_t               vertex_z,
	input logic                          last_vertex,
	input logic                          out_valid,
	input logic                          out_stall,
	input pfn_pkg::norm_t                normal_x,
	input pfn_pkg::norm_t                normal_y,
	input pfn_pkg::norm_t                normal_z,
	input pfn_pkg::idx_t                 corner_a,
	input pfn_pkg::idx_t                 corner_b,
	input pfn_pkg::idx_t                 corner_c,
	input logic                          last_facet
);
	import pfn_pkg::*;

	// A stalled result stays in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(normal_x) && $stable(normal_y)
			&& $stable(normal_z) && $stable(last_facet))
		else $error("stalled result changed");

	// Facet corners are always listed in ascending order.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (corner_a < corner_b) && (corner_b < corner_c))
		else $error("facet corners out of order");

	// A unit normal component never reaches the most negative code.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (normal_x != NORM_MIN) && (normal_y != NORM_MIN)
			&& (normal_z != NORM_MIN))
		else $error("normal component out of range");

	// The second facet of a quad split along the 1-3 diagonal is always the final one.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && corner_a == 2'd1 |-> last_facet)
		else $error("second quad facet not marked last");

endmodule

bind polygon_facet_normals pfn_checker u_pfn_checker (.*);

FILE: test/tb_polygon_facet_normals.sv
// ----------------------------------------------------------------------------
// tb_polygon_facet_normals
// Self-checking bench for the polygon facet normal block.
// ----------------------------------------------------------------------------
// An initial block builds polygons (directed corner cases first, then random
// well-formed triangles and quads mixed with short and overlong polygons) and
// puts their corners in a queue. A clocked driver hands them to the block, and
// each accepted corner also runs through a local model of the facet split,
// cross product, threshold test and normalization. The facets that the model
// predicts wait in a queue until the clocked monitor compares them, field by
// field, against what the block sends. The run goes through four phases with
// different thresholds and different amounts of idling on both channels.
// ----------------------------------------------------------------------------
module tb_polygon_facet_normals;
	timeunit 1ns;
	timeprecision 1ps;

	import pfn_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   last;
	} corner_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [THR_WIDTH-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	coord_t vertex_x = '0;
	coord_t vertex_y = '0;
	coord_t vertex_z = '0;
	logic last_vertex = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	norm_t normal_x;
	norm_t normal_y;
	norm_t normal_z;
	idx_t corner_a;
	idx_t corner_b;
	idx_t corner_c;
	logic last_facet;

	corner_t pending_corners[$];
	result_t expected_facets[$];

	// Local copy of the block's polygon state and threshold.
	coord_t store_x[4];
	coord_t store_y[4];
	coord_t store_z[4];
	int unsigned stored_count = 0;
	logic [THR_WIDTH-1:0] threshold = THR_RESET;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int quiet_cycles = 0;

	always #1 clk = ~clk;

	polygon_facet_normals uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.vertex_z(vertex_z),
		.last_vertex(last_vertex),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.normal_x(normal_x),
		.normal_y(normal_y),
		.normal_z(normal_z),
		.corner_a(corner_a),
		.corner_b(corner_b),
		.corner_c(corner_c),
		.last_facet(last_facet)
	);

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	function automatic int bit_length(input logic [63:0] v);
		int n;
		n = 0;
		while (v != 0) begin
			n++;
			v = v >> 1;
		end
		return n;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] s);
		logic [63:0] root;
		logic [63:0] probe;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > s) probe = probe >> 2;
		while (probe != 0) begin
			if (s >= root + probe) begin
				s = s - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	// Squared distance between two stored corners; it fits easily in 64 bits.
	function automatic longint diagonal_sq(input int p, input int q);
		longint dx, dy, dz;
		dx = longint'(store_x[p]) - longint'(store_x[q]);
		dy = longint'(store_y[p]) - longint'(store_y[q]);
		dz = longint'(store_z[p]) - longint'(store_z[q]);
		return dx * dx + dy * dy + dz * dz;
	endfunction

	// Builds the facet a,b,c; returns 0 when the facet is degenerate.
	function automatic bit facet_normal(input int a, input int b, input int c,
			output result_t f);
		longint ux, uy, uz, vx, vy, vz;
		longint cr[3];
		logic [63:0] mag[3];
		logic [63:0] r[3];
		logic [63:0] sum, len, q;
		bit degenerate;
		int bmax;
		ux = longint'(store_x[b]) - longint'(store_x[a]);
		uy = longint'(store_y[b]) - longint'(store_y[a]);
		uz = longint'(store_z[b]) - longint'(store_z[a]);
		vx = longint'(store_x[c]) - longint'(store_x[a]);
		vy = longint'(store_y[c]) - longint'(store_y[a]);
		vz = longint'(store_z[c]) - longint'(store_z[a]);
		cr[0] = uy * vz - uz * vy;
		cr[1] = uz * vx - ux * vz;
		cr[2] = ux * vy - uy * vx;
		degenerate = 1'b1;
		bmax = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = (cr[i] < 0) ? -cr[i] : cr[i];
			if (mag[i] >= 64'(threshold)) degenerate = 1'b0;
			if (bit_length(mag[i]) > bmax) bmax = bit_length(mag[i]);
		end
		f = '0;
		if (degenerate) return 1'b0;
		f.ca = idx_t'(a);
		f.cb = idx_t'(b);
		f.cc = idx_t'(c);
		if (bmax == 0) return 1'b1;
		// Scale so that the largest magnitude has exactly 31 bits.
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			r[i] = (bmax > R_W) ? (mag[i] >> (bmax - R_W)) : (mag[i] << (R_W - bmax));
			sum = sum + r[i] * r[i];
		end
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = (r[i] * 64'(SCALE) + (len >> 1)) / len;
			if (cr[i] < 0) q = -q;
			if (i == 0) f.nx = norm_t'(q);
			else if (i == 1) f.ny = norm_t'(q);
			else f.nz = norm_t'(q);
		end
		return 1'b1;
	endfunction

	// Takes one accepted corner and queues the facets it completes.
	task automatic take_corner(input corner_t cn);
		result_t found[$];
		result_t f;
		int n;
		if (stored_count < 4) begin
			store_x[stored_count] = cn.x;
			store_y[stored_count] = cn.y;
			store_z[stored_count] = cn.z;
			stored_count++;
		end
		if (!cn.last) return;
		n = stored_count;
		stored_count = 0;
		if (n == 3) begin
			if (facet_normal(0, 1, 2, f)) found.push_back(f);
		end else if (n == 4) begin
			// Split along the shorter diagonal; a tie takes the 1-3 diagonal.
			if (diagonal_sq(0, 2) < diagonal_sq(1, 3)) begin
				if (facet_normal(0, 1, 2, f)) found.push_back(f);
				if (facet_normal(0, 2, 3, f)) found.push_back(f);
			end else begin
				if (facet_normal(0, 1, 3, f)) found.push_back(f);
				if (facet_normal(1, 2, 3, f)) found.push_back(f);
			end
		end
		foreach (found[i]) begin
			found[i].last = (i == found.size() - 1);
			expected_facets.push_back(found[i]);
		end
	endtask

	// Driver: a held corner stays put until it is taken, then the next one is
	// picked from the queue unless the sender chooses to idle this cycle.
	always @(posedge clk) begin
		corner_t nxt;
		logic take;
		if (arst_n) begin
			take = !in_valid || !in_stall;
			if (in_valid && !in_stall)
				take_corner({vertex_x, vertex_y, vertex_z, last_vertex});
			if (take) begin
				if (pending_corners.size() != 0 &&
						$urandom_range(99) >= send_idle_pct) begin
					nxt = pending_corners.pop_front();
					in_valid <= 1'b1;
					vertex_x <= nxt.x;
					vertex_y <= nxt.y;
					vertex_z <= nxt.z;
					last_vertex <= nxt.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares every taken facet with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_facets.size() == 0) begin
					report_mismatch("facet arrived with none predicted");
				end else begin
					want = expected_facets.pop_front();
					if (normal_x !== want.nx)
						report_mismatch($sformatf("normal_x %0d, want %0d", normal_x, want.nx));
					if (normal_y !== want.ny)
						report_mismatch($sformatf("normal_y %0d, want %0d", normal_y, want.ny));
					if (normal_z !== want.nz)
						report_mismatch($sformatf("normal_z %0d, want %0d", normal_z, want.nz));
					if (corner_a !== want.ca)
						report_mismatch($sformatf("corner_a %0d, want %0d", corner_a, want.ca));
					if (corner_b !== want.cb)
						report_mismatch($sformatf("corner_b %0d, want %0d", corner_b, want.cb));
					if (corner_c !== want.cc)
						report_mismatch($sformatf("corner_c %0d, want %0d", corner_c, want.cc));
					if (last_facet !== want.last)
						report_mismatch($sformatf("last_facet %0b, want %0b", last_facet,
							want.last));
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog: too long without any transaction on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic add_corner(input int x, input int y, input int z, input logic last);
		pending_corners.push_back({coord_t'(x), coord_t'(y), coord_t'(z), last});
	endtask

	// Random coordinate: full range, a small window that makes near-degenerate
	// facets likely, or a medium range.
	function automatic int random_coord(input int kind);
		if (kind == 0) return int'(coord_t'($urandom));
		if (kind == 1) return $urandom_range(6) - 3;
		return $urandom_range(8000) - 4000;
	endfunction

	task automatic add_directed_polygons();
		int hi, lo;
		hi = 8388607;
		lo = -8388608;
		// Plain triangle in the xy plane.
		add_corner(0, 0, 0, 0); add_corner(4096, 0, 0, 0); add_corner(0, 4096, 0, 1);
		// Collinear triangle: zero cross product.
		add_corner(0, 0, 0, 0); add_corner(1, 1, 1, 0); add_corner(2, 2, 2, 1);
		// Extreme coordinates.
		add_corner(lo, lo, lo, 0); add_corner(hi, lo, hi, 0); add_corner(lo, hi, hi, 1);
		// Square: equal diagonals.
		add_corner(0, 0, 0, 0); add_corner(100, 0, 0, 0);
		add_corner(100, 100, 0, 0); add_corner(0, 100, 0, 1);
		// Quad whose 0-2 diagonal is shorter.
		add_corner(0, 0, 5, 0); add_corner(300, -50, 0, 0);
		add_corner(10, 10, 0, 0); add_corner(-40, 300, 7, 1);
		// Short polygons, a lone corner, then an overlong one.
		add_corner(5, 5, 5, 1);
		add_corner(hi, hi, hi, 0); add_corner(lo, 0, hi, 1);
		add_corner(0, 0, 0, 0); add_corner(1, 0, 0, 0); add_corner(0, 1, 0, 0);
		add_corner(0, 0, 1, 0); add_corner(hi, 7, lo, 0); add_corner(9, 9, 9, 1);
	endtask

	task automatic add_random_polygons(input int count);
		int n, kind, bx, by, bz;
		for (int p = 0; p < count; p++) begin
			kind = $urandom_range(2);
			// Most polygons are triangles or quads; some are short or long.
			if ($urandom_range(9) < 8) n = 3 + $urandom_range(1);
			else n = ($urandom_range(1) == 0) ? 1 + $urandom_range(1) : 5 + $urandom_range(2);
			bx = (kind == 1) ? random_coord(2) : 0;
			by = (kind == 1) ? random_coord(2) : 0;
			bz = (kind == 1) ? random_coord(2) : 0;
			for (int i = 0; i < n; i++)
				add_corner(bx + random_coord(kind), by + random_coord(kind),
					bz + random_coord(kind), i == n - 1);
		end
	endtask

	task automatic write_threshold(input logic [THR_WIDTH-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		threshold = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		add_directed_polygons();
		add_random_polygons(50);
		wait (pending_corners.size() == 0 && !in_valid);
		wait (expected_facets.size() == 0);
		// Polygons that end in no facet may still be in the engine.
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// First phase runs with the reset threshold and no idling.
		run_phase(0, 0);
		write_threshold('0);
		run_phase(66, 0);
		write_threshold({THR_WIDTH{1'b1}});
		run_phase(0, 66);
		write_threshold(THR_WIDTH'($urandom_range(5000)));
		run_phase(18, 18);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: polygon_facet_normals.f
rtl/pfn_pkg.sv
rtl/pfn_front.sv
rtl/pfn_queue.sv
rtl/pfn_back.sv
rtl/polygon_facet_normals.sv
rtl/pfn_checker.sv
test/tb_polygon_facet_normals.sv
